### design/ctfc_pkg.sv
// Shared types, constants and prescaler tables for the clock-tree frequency calculator.
// No dependencies; used by ctfc_div, clock_tree_frequency_calc and the testbench.
package ctfc_pkg;

    localparam int CTFC_HZ_W       = 32;
    localparam int CTFC_N_W        = 9;
    localparam int CTFC_M_W        = 6;
    localparam int CTFC_NUM_W      = CTFC_HZ_W + CTFC_N_W;  // oscillator * N
    localparam int CTFC_MP_W       = 8;                     // M * (code+1), at most 252
    localparam int CTFC_DEN_W      = CTFC_MP_W + 1;         // M * P, at most 504
    localparam int CTFC_AHB_SH_W   = 4;
    localparam int CTFC_APB_SH_W   = 3;
    localparam int CTFC_DIV_STEP_BITS = 4;                  // quotient bits per divider stage

    // configuration register indexes
    localparam int CTFC_CFG_IDX_W = 1;
    localparam logic [CTFC_CFG_IDX_W-1:0] CTFC_CFG_EXT_OSC = 1'b0;
    localparam logic [CTFC_CFG_IDX_W-1:0] CTFC_CFG_INT_OSC = 1'b1;

    localparam logic [CTFC_HZ_W-1:0] CTFC_EXT_OSC_RESET = 32'd25000000;
    localparam logic [CTFC_HZ_W-1:0] CTFC_INT_OSC_RESET = 32'd16000000;

    // system clock source codes
    localparam logic [1:0] CTFC_SRC_INT     = 2'd0;
    localparam logic [1:0] CTFC_SRC_EXT     = 2'd1;
    localparam logic [1:0] CTFC_SRC_PLL     = 2'd2;
    localparam logic [1:0] CTFC_SRC_INT_ALT = 2'd3;

    // sideband that travels alongside the divider
    typedef struct packed {
        logic                     pll_sel;
        logic                     div_err;
        logic [CTFC_HZ_W-1:0]     osc_hz;
        logic [CTFC_AHB_SH_W-1:0] ahb_sh;
        logic [CTFC_APB_SH_W-1:0] apb1_sh;
        logic [CTFC_APB_SH_W-1:0] apb2_sh;
    } ctfc_side_t;

    // AHB prescaler: no divide-by-32 step
    function automatic logic [CTFC_AHB_SH_W-1:0] ahb_prescale_sh(input logic [3:0] code);
        logic [CTFC_AHB_SH_W-1:0] sh;
        unique case (code)
            4'd8:    sh = 4'd1;
            4'd9:    sh = 4'd2;
            4'd10:   sh = 4'd3;
            4'd11:   sh = 4'd4;
            4'd12:   sh = 4'd6;
            4'd13:   sh = 4'd7;
            4'd14:   sh = 4'd8;
            4'd15:   sh = 4'd9;
            default: sh = 4'd0;
        endcase
        return sh;
    endfunction

    function automatic logic [CTFC_APB_SH_W-1:0] apb_prescale_sh(input logic [2:0] code);
        logic [CTFC_APB_SH_W-1:0] sh;
        unique case (code)
            3'd4:    sh = 3'd1;
            3'd5:    sh = 3'd2;
            3'd6:    sh = 3'd3;
            3'd7:    sh = 3'd4;
            default: sh = 3'd0;
        endcase
        return sh;
    endfunction

endpackage

### design/ctfc_div.sv
// Pipelined restoring divider with a sideband word carried alongside.
// Depends on ctfc_pkg for the sideband type.
module ctfc_div
    import ctfc_pkg::*;
#(
    parameter int NUM_W     = CTFC_NUM_W,
    parameter int DEN_W     = CTFC_DEN_W,
    parameter int QUOT_W    = CTFC_HZ_W,
    parameter int STEP_BITS = CTFC_DIV_STEP_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  ctfc_side_t        in_side,
    output logic              out_valid,
    output logic [QUOT_W-1:0] out_quot,
    output ctfc_side_t        out_side
);

    localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = STAGES * STEP_BITS;

    logic              valid_reg [0:STAGES-1];
    logic [DEN_W-1:0]  rem_reg   [0:STAGES-1];
    logic [PAD_W-1:0]  acc_reg   [0:STAGES-1];
    logic [DEN_W-1:0]  den_reg   [0:STAGES-1];
    ctfc_side_t        side_reg  [0:STAGES-1];

    genvar s, j;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic             valid_in;
            logic [DEN_W-1:0] rem_in;
            logic [PAD_W-1:0] acc_in;
            logic [DEN_W-1:0] den_in;
            ctfc_side_t       side_in;
            logic [DEN_W-1:0] rem_w   [0:STEP_BITS];
            logic [PAD_W-1:0] acc_w   [0:STEP_BITS];
            logic [DEN_W:0]   trial_w [0:STEP_BITS-1];
            logic             ge_w    [0:STEP_BITS-1];

            if (s == 0)
            begin : g_first
                assign valid_in = in_valid;
                assign rem_in   = '0;
                assign acc_in   = PAD_W'(in_num);
                assign den_in   = in_den;
                assign side_in  = in_side;
            end
            else
            begin : g_next
                assign valid_in = valid_reg[s-1];
                assign rem_in   = rem_reg[s-1];
                assign acc_in   = acc_reg[s-1];
                assign den_in   = den_reg[s-1];
                assign side_in  = side_reg[s-1];
            end

            assign rem_w[0] = rem_in;
            assign acc_w[0] = acc_in;

            // one quotient bit per step: shift in the next numerator bit, trial subtract
            for (j = 0; j < STEP_BITS; j++)
            begin : g_step
                assign trial_w[j]  = {rem_w[j], acc_w[j][PAD_W-1]};
                assign ge_w[j]     = (trial_w[j] >= {1'b0, den_in});
                assign rem_w[j+1]  = ge_w[j] ? DEN_W'(trial_w[j] - {1'b0, den_in})
                                             : trial_w[j][DEN_W-1:0];
                assign acc_w[j+1]  = {acc_w[j][PAD_W-2:0], ge_w[j]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (advance)
                begin
                    valid_reg[s] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[s]  <= rem_w[STEP_BITS];
                    acc_reg[s]  <= acc_w[STEP_BITS];
                    den_reg[s]  <= den_in;
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign out_quot  = acc_reg[STAGES-1][QUOT_W-1:0];
    assign out_side  = side_reg[STAGES-1];

endmodule

### design/clock_tree_frequency_calc.sv
// Clock-tree frequency calculator top level: operand stage, divider, output register.
// Depends on ctfc_pkg and ctfc_div.
//
// Takes one word of decoded clock-tree settings per cycle and returns the system, AHB,
// APB1, APB2 and both APB timer frequencies in hertz. Throughput is one word per cycle
// while the output does not stall. A word passes the operand register, the STAGES
// registers of the PLL divider, where STAGES = ceil(41 / DIV_STEP_BITS), and the output
// register. The divider divides the 41-bit product oscillator * N by M * P, taking
// DIV_STEP_BITS (four by default) quotient bits per stage. A word stalled at the output
// holds every stage. The oscillator frequencies sit in two configuration registers
// (index 0 external, index 1 internal); write them only while the pipeline is empty.
// PLL selected with M of zero gives all ones on every frequency and raises divide_error.
module clock_tree_frequency_calc
    import ctfc_pkg::*;
#(
    parameter int DIV_STEP_BITS = CTFC_DIV_STEP_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CTFC_CFG_IDX_W-1:0] cfg_index,
    input  logic [CTFC_HZ_W-1:0]      cfg_data,

    // settings in
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                clock_source,
    input  logic [CTFC_M_W-1:0]       pll_m,
    input  logic [CTFC_N_W-1:0]       pll_n,
    input  logic [1:0]                pll_p_code,
    input  logic                      pll_from_external,
    input  logic [3:0]                ahb_code,
    input  logic [2:0]                apb1_code,
    input  logic [2:0]                apb2_code,

    // frequencies out
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CTFC_HZ_W-1:0]      system_hz,
    output logic [CTFC_HZ_W-1:0]      ahb_hz,
    output logic [CTFC_HZ_W-1:0]      apb1_hz,
    output logic [CTFC_HZ_W-1:0]      apb2_hz,
    output logic [CTFC_HZ_W-1:0]      apb1_timer_hz,
    output logic [CTFC_HZ_W-1:0]      apb2_timer_hz,
    output logic                      divide_error
);

    // ---------------------------------------------------------------------
    // Configuration registers: always ready, each write taken in its valid cycle
    // ---------------------------------------------------------------------
    logic [CTFC_HZ_W-1:0] ext_osc_reg;
    logic [CTFC_HZ_W-1:0] int_osc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_osc_reg <= CTFC_EXT_OSC_RESET;
            int_osc_reg <= CTFC_INT_OSC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CTFC_CFG_EXT_OSC: ext_osc_reg <= cfg_data;
                CTFC_CFG_INT_OSC: int_osc_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Flow control: every stage advances together unless a finished word
    // waits at the output and the sink stalls it.
    // ---------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // ---------------------------------------------------------------------
    // Operand stage: build numerator oscillator * N, divisor M * P, decode
    // the source and the prescaler shifts.
    // ---------------------------------------------------------------------
    logic [CTFC_HZ_W-1:0]  pll_in_hz;
    logic [2:0]            p_half;
    logic [CTFC_MP_W-1:0]  mp_prod;
    logic [CTFC_NUM_W-1:0] num_next;
    logic [CTFC_DEN_W-1:0] den_next;
    ctfc_side_t            side_next;

    logic                  op_valid_reg;
    logic [CTFC_NUM_W-1:0] num_reg;
    logic [CTFC_DEN_W-1:0] den_reg;
    ctfc_side_t            side_reg;

    assign pll_in_hz = pll_from_external ? ext_osc_reg : int_osc_reg;
    assign p_half    = {1'b0, pll_p_code} + 3'd1;                 // P / 2
    assign mp_prod   = {2'b00, pll_m} * {5'b00000, p_half};
    assign den_next  = {mp_prod, 1'b0};
    assign num_next  = {{CTFC_N_W{1'b0}}, pll_in_hz} * {{CTFC_HZ_W{1'b0}}, pll_n};

    always_comb
    begin
        side_next.pll_sel = (clock_source == CTFC_SRC_PLL);
        side_next.div_err = (clock_source == CTFC_SRC_PLL) && (pll_m == '0);
        // codes zero and three both pick the internal oscillator
        side_next.osc_hz  = (clock_source == CTFC_SRC_EXT) ? ext_osc_reg : int_osc_reg;
        side_next.ahb_sh  = ahb_prescale_sh(ahb_code);
        side_next.apb1_sh = apb_prescale_sh(apb1_code);
        side_next.apb2_sh = apb_prescale_sh(apb2_code);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            op_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    // ---------------------------------------------------------------------
    // PLL divider: quotient keeps its low 32 bits
    // ---------------------------------------------------------------------
    logic                 div_valid;
    logic [CTFC_HZ_W-1:0] div_quot;
    ctfc_side_t           div_side;

    ctfc_div #(
        .NUM_W     (CTFC_NUM_W),
        .DEN_W     (CTFC_DEN_W),
        .QUOT_W    (CTFC_HZ_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (op_valid_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_side   (side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ---------------------------------------------------------------------
    // Bus tree and output register
    // ---------------------------------------------------------------------
    logic [CTFC_HZ_W-1:0] sys_next;
    logic [CTFC_HZ_W-1:0] ahb_next;
    logic [CTFC_HZ_W-1:0] apb1_next;
    logic [CTFC_HZ_W-1:0] apb2_next;
    logic [CTFC_HZ_W-1:0] tim1_next;
    logic [CTFC_HZ_W-1:0] tim2_next;

    logic [CTFC_HZ_W-1:0] sys_reg;
    logic [CTFC_HZ_W-1:0] ahb_reg;
    logic [CTFC_HZ_W-1:0] apb1_reg;
    logic [CTFC_HZ_W-1:0] apb2_reg;
    logic [CTFC_HZ_W-1:0] tim1_reg;
    logic [CTFC_HZ_W-1:0] tim2_reg;
    logic                 err_reg;

    always_comb
    begin
        sys_next  = div_side.pll_sel ? div_quot : div_side.osc_hz;
        ahb_next  = sys_next >> div_side.ahb_sh;
        apb1_next = ahb_next >> div_side.apb1_sh;
        apb2_next = ahb_next >> div_side.apb2_sh;
        // timer clock doubles whenever its APB prescaler divides; wraps at 32 bits
        tim1_next = (div_side.apb1_sh == '0) ? apb1_next : {apb1_next[CTFC_HZ_W-2:0], 1'b0};
        tim2_next = (div_side.apb2_sh == '0) ? apb2_next : {apb2_next[CTFC_HZ_W-2:0], 1'b0};
        if (div_side.div_err)
        begin
            // drop the tree: every frequency reads all ones
            sys_next  = '1;
            ahb_next  = '1;
            apb1_next = '1;
            apb2_next = '1;
            tim1_next = '1;
            tim2_next = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sys_reg  <= sys_next;
            ahb_reg  <= ahb_next;
            apb1_reg <= apb1_next;
            apb2_reg <= apb2_next;
            tim1_reg <= tim1_next;
            tim2_reg <= tim2_next;
            err_reg  <= div_side.div_err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign system_hz     = sys_reg;
    assign ahb_hz        = ahb_reg;
    assign apb1_hz       = apb1_reg;
    assign apb2_hz       = apb2_reg;
    assign apb1_timer_hz = tim1_reg;
    assign apb2_timer_hz = tim2_reg;
    assign divide_error  = err_reg;

endmodule

### tb/sv/clock_tree_frequency_calc_checker.sv
`timescale 1ns / 100ps
// Checker for clock_tree_frequency_calc: watches the config, settings and frequency channels,
// predicts every frequency word and compares it field by field. Depends on ctfc_pkg.
module clock_tree_frequency_calc_checker
    import ctfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CTFC_CFG_IDX_W-1:0] cfg_index,
    input  logic [CTFC_HZ_W-1:0]      cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                clock_source,
    input  logic [CTFC_M_W-1:0]       pll_m,
    input  logic [CTFC_N_W-1:0]       pll_n,
    input  logic [1:0]                pll_p_code,
    input  logic                      pll_from_external,
    input  logic [3:0]                ahb_code,
    input  logic [2:0]                apb1_code,
    input  logic [2:0]                apb2_code,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [CTFC_HZ_W-1:0]      system_hz,
    input  logic [CTFC_HZ_W-1:0]      ahb_hz,
    input  logic [CTFC_HZ_W-1:0]      apb1_hz,
    input  logic [CTFC_HZ_W-1:0]      apb2_hz,
    input  logic [CTFC_HZ_W-1:0]      apb1_timer_hz,
    input  logic [CTFC_HZ_W-1:0]      apb2_timer_hz,
    input  logic                      divide_error,
    output int                        fail_count,
    output int                        waiting_count
);

    typedef struct packed {
        logic [CTFC_HZ_W-1:0] system_hz;
        logic [CTFC_HZ_W-1:0] ahb_hz;
        logic [CTFC_HZ_W-1:0] apb1_hz;
        logic [CTFC_HZ_W-1:0] apb2_hz;
        logic [CTFC_HZ_W-1:0] apb1_timer_hz;
        logic [CTFC_HZ_W-1:0] apb2_timer_hz;
        logic                 divide_error;
    } freq_set_t;

    // prescaler shifts; the AHB table skips divide-by-32
    localparam logic [3:0] AHB_PRESCALE_SH [16] = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
                                                    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7,
                                                    4'd8, 4'd9};
    localparam logic [2:0] APB_PRESCALE_SH [8]  = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3,
                                                    3'd4};

    logic [CTFC_HZ_W-1:0] ext_osc;
    logic [CTFC_HZ_W-1:0] int_osc;
    freq_set_t            freq_queue [$];

    function automatic freq_set_t predict_freqs(input logic [1:0] src, input logic [5:0] m,
                                                input logic [8:0] n, input logic [1:0] p_code,
                                                input logic from_ext, input logic [3:0] ahb,
                                                input logic [2:0] apb1, input logic [2:0] apb2);
        logic [63:0]          pll_in;
        logic [63:0]          divisor;
        logic [63:0]          quotient;
        logic [CTFC_HZ_W-1:0] sys;
        logic [2:0]           sh1;
        logic [2:0]           sh2;
        freq_set_t            f;
        // PLL chosen with no input divider: everything saturates and the flag goes up
        if (src == CTFC_SRC_PLL && m == '0)
        begin
            f = '1;
            return f;
        end
        case (src)
            CTFC_SRC_EXT: sys = ext_osc;
            CTFC_SRC_PLL:
            begin
                pll_in   = from_ext ? 64'(ext_osc) : 64'(int_osc);
                divisor  = 64'(m) * ((64'(p_code) + 64'd1) * 64'd2);
                quotient = (pll_in * 64'(n)) / divisor;
                sys      = quotient[CTFC_HZ_W-1:0];
            end
            default:      sys = int_osc;
        endcase
        sh1             = APB_PRESCALE_SH[apb1];
        sh2             = APB_PRESCALE_SH[apb2];
        f.system_hz     = sys;
        f.ahb_hz        = sys >> AHB_PRESCALE_SH[ahb];
        f.apb1_hz       = f.ahb_hz >> sh1;
        f.apb2_hz       = f.ahb_hz >> sh2;
        f.apb1_timer_hz = (sh1 == '0) ? f.apb1_hz : {f.apb1_hz[CTFC_HZ_W-2:0], 1'b0};
        f.apb2_timer_hz = (sh2 == '0) ? f.apb2_hz : {f.apb2_hz[CTFC_HZ_W-2:0], 1'b0};
        f.divide_error  = 1'b0;
        return f;
    endfunction

    function automatic int field_mismatch(input string name, input logic [CTFC_HZ_W-1:0] want,
                                          input logic [CTFC_HZ_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        freq_set_t want;
        freq_set_t got;
        int        bad;
        if (!rst_n)
        begin
            ext_osc       <= CTFC_EXT_OSC_RESET;
            int_osc       <= CTFC_INT_OSC_RESET;
            fail_count    <= 0;
            waiting_count <= 0;
            freq_queue.delete();
        end
        else
        begin
            bad = 0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CTFC_CFG_EXT_OSC)
                    ext_osc <= cfg_data;
                else
                    int_osc <= cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got = {system_hz, ahb_hz, apb1_hz, apb2_hz, apb1_timer_hz, apb2_timer_hz,
                       divide_error};
                if (freq_queue.size() == 0)
                begin
                    $error("frequency word arrived with none expected");
                    bad++;
                end
                else
                begin
                    want = freq_queue.pop_front();
                    bad += field_mismatch("system_hz", want.system_hz, got.system_hz);
                    bad += field_mismatch("ahb_hz", want.ahb_hz, got.ahb_hz);
                    bad += field_mismatch("apb1_hz", want.apb1_hz, got.apb1_hz);
                    bad += field_mismatch("apb2_hz", want.apb2_hz, got.apb2_hz);
                    bad += field_mismatch("apb1_timer_hz", want.apb1_timer_hz,
                                          got.apb1_timer_hz);
                    bad += field_mismatch("apb2_timer_hz", want.apb2_timer_hz,
                                          got.apb2_timer_hz);
                    bad += field_mismatch("divide_error", 32'(want.divide_error),
                                          32'(got.divide_error));
                end
            end
            if (in_valid && !in_stall)
                freq_queue.push_back(predict_freqs(clock_source, pll_m, pll_n, pll_p_code,
                                                   pll_from_external, ahb_code, apb1_code,
                                                   apb2_code));
            fail_count    <= fail_count + bad;
            waiting_count <= freq_queue.size();
        end
    end

endmodule

### tb/sv/clock_tree_frequency_calc_test.sv
`timescale 1ns / 100ps
// Top of the clock_tree_frequency_calc testbench: clock, reset, stimulus and verdict.
// Depends on ctfc_pkg, clock_tree_frequency_calc and clock_tree_frequency_calc_checker.
module clock_tree_frequency_calc_test;
    import ctfc_pkg::*;

    // divider depth plus operand and output stages
    localparam int PIPE_LATENCY  = 13;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 340;
    localparam int NUM_SETTINGS  = 5;

    typedef struct packed {
        logic [1:0] src;
        logic [5:0] m;
        logic [8:0] n;
        logic [1:0] p_code;
        logic       from_ext;
        logic [3:0] ahb;
        logic [2:0] apb1;
        logic [2:0] apb2;
    } clk_settings_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CTFC_CFG_IDX_W-1:0] cfg_index;
    logic [CTFC_HZ_W-1:0]      cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                clock_source;
    logic [CTFC_M_W-1:0]       pll_m;
    logic [CTFC_N_W-1:0]       pll_n;
    logic [1:0]                pll_p_code;
    logic                      pll_from_external;
    logic [3:0]                ahb_code;
    logic [2:0]                apb1_code;
    logic [2:0]                apb2_code;
    logic                      out_valid;
    logic                      out_stall;
    logic [CTFC_HZ_W-1:0]      system_hz;
    logic [CTFC_HZ_W-1:0]      ahb_hz;
    logic [CTFC_HZ_W-1:0]      apb1_hz;
    logic [CTFC_HZ_W-1:0]      apb2_hz;
    logic [CTFC_HZ_W-1:0]      apb1_timer_hz;
    logic [CTFC_HZ_W-1:0]      apb2_timer_hz;
    logic                      divide_error;

    int fail_count;
    int waiting_count;
    int cycle_count;
    // when set, neither side idles: back-to-back words on both channels
    bit steady;

    clock_tree_frequency_calc DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .clock_source      (clock_source),
        .pll_m             (pll_m),
        .pll_n             (pll_n),
        .pll_p_code        (pll_p_code),
        .pll_from_external (pll_from_external),
        .ahb_code          (ahb_code),
        .apb1_code         (apb1_code),
        .apb2_code         (apb2_code),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .system_hz         (system_hz),
        .ahb_hz            (ahb_hz),
        .apb1_hz           (apb1_hz),
        .apb2_hz           (apb2_hz),
        .apb1_timer_hz     (apb1_timer_hz),
        .apb2_timer_hz     (apb2_timer_hz),
        .divide_error      (divide_error)
    );

    clock_tree_frequency_calc_checker freq_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the pipeline hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic clk_settings_t make_settings(input logic [1:0] src, input logic [5:0] m,
                                                    input logic [8:0] n, input logic [1:0] p_code,
                                                    input logic from_ext, input logic [3:0] ahb,
                                                    input logic [2:0] apb1, input logic [2:0] apb2);
        return '{src, m, n, p_code, from_ext, ahb, apb1, apb2};
    endfunction

    // mostly PLL settings with a usable divider, some raw noise and the odd zero M
    function automatic clk_settings_t random_settings();
        clk_settings_t s;
        s.src      = ($urandom_range(0, 9) < 5) ? CTFC_SRC_PLL : 2'($urandom_range(0, 3));
        s.m        = ($urandom_range(0, 15) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
        s.n        = 9'($urandom_range(0, 511));
        s.p_code   = 2'($urandom_range(0, 3));
        s.from_ext = 1'($urandom_range(0, 1));
        s.ahb      = 4'($urandom_range(0, 15));
        s.apb1     = 3'($urandom_range(0, 7));
        s.apb2     = 3'($urandom_range(0, 7));
        return s;
    endfunction

    // Present one word after a random gap and hold it until accepted. Valid stays high on
    // return, so a following word with no gap keeps the channel busy.
    task automatic send_word(input clk_settings_t s);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        clock_source      <= s.src;
        pll_m             <= s.m;
        pll_n             <= s.n;
        pll_p_code        <= s.p_code;
        pll_from_external <= s.from_ext;
        ahb_code          <= s.ahb;
        apb1_code         <= s.apb1;
        apb2_code         <= s.apb2;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait for the pipeline to empty, then let it go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting_count != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CTFC_CFG_IDX_W-1:0] idx,
                             input logic [CTFC_HZ_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sources of every code, M zero with and without the PLL, divider extremes and
    // every prescaler code on both buses.
    task automatic run_directed();
        send_word(make_settings(CTFC_SRC_INT, 6'd0, 9'd0, 2'd0, 1'b0, 4'd0, 3'd0, 3'd0));
        send_word(make_settings(CTFC_SRC_EXT, 6'd4, 9'd100, 2'd1, 1'b1, 4'd0, 3'd0, 3'd0));
        send_word(make_settings(CTFC_SRC_INT_ALT, 6'd63, 9'd511, 2'd3, 1'b1, 4'd15, 3'd7, 3'd7));
        send_word(make_settings(CTFC_SRC_PLL, 6'd0, 9'd336, 2'd1, 1'b1, 4'd0, 3'd4, 3'd0));
        send_word(make_settings(CTFC_SRC_INT, 6'd0, 9'd511, 2'd3, 1'b1, 4'd8, 3'd5, 3'd6));
        send_word(make_settings(CTFC_SRC_PLL, 6'd1, 9'd511, 2'd0, 1'b1, 4'd0, 3'd0, 3'd4));
        send_word(make_settings(CTFC_SRC_PLL, 6'd1, 9'd511, 2'd0, 1'b0, 4'd0, 3'd7, 3'd0));
        send_word(make_settings(CTFC_SRC_PLL, 6'd63, 9'd511, 2'd3, 1'b0, 4'd0, 3'd0, 3'd0));
        send_word(make_settings(CTFC_SRC_PLL, 6'd63, 9'd0, 2'd3, 1'b1, 4'd0, 3'd0, 3'd0));
        for (int code = 0; code < 16; code++)
            send_word(make_settings(CTFC_SRC_PLL, 6'd8, 9'd336, 2'd1, 1'b1, 4'(code),
                                    3'(code), 3'(7 - (code % 8))));
    endtask

    task automatic run_random();
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // switch between idling and back-to-back stretches now and then
            if (i % 60 == 0)
                steady = ($urandom_range(0, 3) == 0);
            // hold off once mid-phase until every pending word is back
            if (i == RANDOM_WORDS / 2)
                settle();
            send_word(random_settings());
        end
        steady = 1'b0;
    endtask

    // Receiver: stall a random number of cycles before each word, then take it.
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            int hold;
            hold = draw_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        logic [CTFC_HZ_W-1:0] ext_settings [NUM_SETTINGS];
        logic [CTFC_HZ_W-1:0] int_settings [NUM_SETTINGS];
        cycle_count       = 0;
        steady            = 1'b0;
        rst_n             = 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= CTFC_CFG_EXT_OSC;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        clock_source      <= CTFC_SRC_INT;
        pll_m             <= '0;
        pll_n             <= '0;
        pll_p_code        <= '0;
        pll_from_external <= 1'b0;
        ahb_code          <= '0;
        apb1_code         <= '0;
        apb2_code         <= '0;

        // oscillator pairs: zeros, full scale, lopsided, random, a typical board
        ext_settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'($urandom), 32'd8_000_000};
        int_settings = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'($urandom), 32'd1};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first phase runs on the reset oscillator values
        run_directed();
        run_random();
        for (int k = 0; k < NUM_SETTINGS; k++)
        begin
            settle();
            write_reg(CTFC_CFG_EXT_OSC, ext_settings[k]);
            write_reg(CTFC_CFG_INT_OSC, int_settings[k]);
            run_directed();
            run_random();
        end
        settle();

        if (fail_count == 0 && waiting_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
design/ctfc_pkg.sv
design/ctfc_div.sv
design/clock_tree_frequency_calc.sv
tb/sv/clock_tree_frequency_calc_checker.sv
tb/sv/clock_tree_frequency_calc_test.sv
